// ----- design/eps_pkg.sv -----
`default_nettype none

package eps_pkg;

  localparam int unsigned END_YEAR     = 2100;
  localparam int unsigned BASE_YEAR    = 1900;
  localparam int unsigned EPOCH_YEAR   = 1970;
  localparam int unsigned SECS_PER_DAY = 86400;
  localparam int unsigned SECS_PER_HR  = 3600;
  localparam int unsigned SECS_PER_MIN = 60;
  localparam int unsigned DAYS_PER_WK  = 7;
  localparam int unsigned EPOCH_WDAY   = 4;
  localparam int unsigned LAST_MONTH   = 11;

  localparam int unsigned OPW = 18;

  localparam logic [7:0] END_OFF   = 8'(END_YEAR - BASE_YEAR);
  localparam logic [7:0] EPOCH_OFF = 8'(EPOCH_YEAR - BASE_YEAR);
  localparam logic [7:0] Y2100_OFF = 8'(2100 - BASE_YEAR);

  typedef struct packed {
    logic           ge;
    logic [OPW-1:0] diff;
  } cs_res_t;

  // Only century met in 1970..2106 that is not a leap year is 2100.
  function automatic logic is_leap(input logic [7:0] yoff);
    is_leap = (yoff[1:0] == 2'b00) && (yoff != Y2100_OFF);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    case (mon)
      4'd1:                      month_len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   month_len = 5'd30;
      default:                   month_len = 5'd31;
    endcase
  endfunction

endpackage

`default_nettype wire

// ----- design/epoch_seconds_to_utc_calendar.sv -----
// Channel   Direction  Ports                              Handshake
// in_       input      in_epoch_seconds                   in_valid / in_stall
// out_      output     out_valid_res .. out_day_of_year   out_valid / out_stall
//
// One transaction at a time through a single compare-subtract unit.
// Steps: restoring divide by 86400, (days + 4) mod 7 for the weekday, then walks
// of years, months, hours and minutes; from END_YEAR on, out_valid_res is low.
// rst_n synchronously returns the sequencer to idle; no clearing pass.
// in_stall is high from accept until the result is taken; the result holds
// while out_stall is high.
`default_nettype none

module epoch_seconds_to_utc_calendar
  import eps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_epoch_seconds,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_valid_res,
  output logic [7:0]       out_years_since_1900,
  output logic [3:0]       out_month_index,
  output logic [4:0]       out_day_of_month,
  output logic [4:0]       out_hour_of_day,
  output logic [5:0]       out_minute_of_hour,
  output logic [5:0]       out_second_of_minute,
  output logic [2:0]       out_weekday,
  output logic [8:0]       out_day_of_year
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DIVD = 8'b0000_0010,
    S_WDAY = 8'b0000_0100,
    S_YEAR = 8'b0000_1000,
    S_MON  = 8'b0001_0000,
    S_HOUR = 8'b0010_0000,
    S_MIN  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t      state_r, state_nxt;
  logic [31:0] num_r, num_nxt;
  logic [16:0] acc_r, acc_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [15:0] days_r, days_nxt;
  logic [16:0] secs_r, secs_nxt;
  logic [15:0] d_r, d_nxt;
  logic [8:0]  doy_r, doy_nxt;
  logic [7:0]  yoff_r, yoff_nxt;
  logic [3:0]  mon_r, mon_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [2:0]  wday_r, wday_nxt;
  logic        ok_r, ok_nxt;

  logic [OPW-1:0] op_a, op_b;
  cs_res_t        cs;
  logic [15:0]    days_p4;

  eps_cmpsub u_cmpsub (
    .a   (op_a),
    .b   (op_b),
    .res (cs)
  );

  assign days_p4 = {num_r[14:0], cs.ge} + 16'(EPOCH_WDAY);

  always_comb begin
    op_a = {acc_r, num_r[31]};
    op_b = OPW'(SECS_PER_DAY);
    unique case (state_r)
      S_DIVD: begin
        op_a = {acc_r, num_r[31]};
        op_b = OPW'(SECS_PER_DAY);
      end
      S_WDAY: begin
        op_a = {acc_r, num_r[31]};
        op_b = OPW'(DAYS_PER_WK);
      end
      S_YEAR: begin
        op_a = {2'b00, d_r};
        op_b = is_leap(yoff_r) ? OPW'(366) : OPW'(365);
      end
      S_MON: begin
        op_a = {2'b00, d_r};
        op_b = OPW'(month_len(mon_r, is_leap(yoff_r)));
      end
      S_HOUR: begin
        op_a = {1'b0, secs_r};
        op_b = OPW'(SECS_PER_HR);
      end
      S_MIN: begin
        op_a = {1'b0, secs_r};
        op_b = OPW'(SECS_PER_MIN);
      end
      S_IDLE, S_DONE: begin
        op_a = {acc_r, num_r[31]};
        op_b = OPW'(SECS_PER_DAY);
      end
      default: begin
        op_a = {acc_r, num_r[31]};
        op_b = OPW'(SECS_PER_DAY);
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    num_nxt   = num_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    days_nxt  = days_r;
    secs_nxt  = secs_r;
    d_nxt     = d_r;
    doy_nxt   = doy_r;
    yoff_nxt  = yoff_r;
    mon_nxt   = mon_r;
    hour_nxt  = hour_r;
    min_nxt   = min_r;
    wday_nxt  = wday_r;
    ok_nxt    = ok_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          num_nxt   = in_epoch_seconds;
          acc_nxt   = '0;
          cnt_nxt   = 5'd31;
          state_nxt = S_DIVD;
        end
      end
      S_DIVD, S_WDAY: begin
        acc_nxt = cs.ge ? cs.diff[16:0] : op_a[16:0];
        num_nxt = {num_r[30:0], cs.ge};
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          if (state_r == S_DIVD) begin
            days_nxt  = num_nxt[15:0];
            secs_nxt  = acc_nxt;
            num_nxt   = {days_p4, 16'h0000};
            acc_nxt   = '0;
            cnt_nxt   = 5'd15;
            state_nxt = S_WDAY;
          end else begin
            wday_nxt  = acc_nxt[2:0];
            d_nxt     = days_r;
            yoff_nxt  = EPOCH_OFF;
            state_nxt = S_YEAR;
          end
        end
      end
      S_YEAR: begin
        if (yoff_r == END_OFF) begin
          ok_nxt    = 1'b0;
          state_nxt = S_DONE;
        end else if (cs.ge) begin
          d_nxt    = cs.diff[15:0];
          yoff_nxt = yoff_r + 8'd1;
        end else begin
          ok_nxt    = 1'b1;
          doy_nxt   = d_r[8:0];
          mon_nxt   = '0;
          state_nxt = S_MON;
        end
      end
      S_MON: begin
        if (mon_r != 4'(LAST_MONTH) && cs.ge) begin
          d_nxt   = cs.diff[15:0];
          mon_nxt = mon_r + 4'd1;
        end else begin
          hour_nxt  = '0;
          state_nxt = S_HOUR;
        end
      end
      S_HOUR: begin
        if (cs.ge) begin
          secs_nxt = cs.diff[16:0];
          hour_nxt = hour_r + 5'd1;
        end else begin
          min_nxt   = '0;
          state_nxt = S_MIN;
        end
      end
      S_MIN: begin
        if (cs.ge) begin
          secs_nxt = cs.diff[16:0];
          min_nxt  = min_r + 6'd1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    acc_r  <= acc_nxt;
    cnt_r  <= cnt_nxt;
    days_r <= days_nxt;
    secs_r <= secs_nxt;
    d_r    <= d_nxt;
    doy_r  <= doy_nxt;
    yoff_r <= yoff_nxt;
    mon_r  <= mon_nxt;
    hour_r <= hour_nxt;
    min_r  <= min_nxt;
    wday_r <= wday_nxt;
    ok_r   <= ok_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

  assign out_valid_res        = ok_r;
  assign out_years_since_1900 = ok_r ? yoff_r : '0;
  assign out_month_index      = ok_r ? mon_r : '0;
  assign out_day_of_month     = ok_r ? (d_r[4:0] + 5'd1) : '0;
  assign out_hour_of_day      = ok_r ? hour_r : '0;
  assign out_minute_of_hour   = ok_r ? min_r : '0;
  assign out_second_of_minute = ok_r ? secs_r[5:0] : '0;
  assign out_weekday          = ok_r ? wday_r : '0;
  assign out_day_of_year      = ok_r ? doy_r : '0;

  a_busy_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("result shown while input open");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !out_valid)
    else $error("result in cycle after accept");

  a_fields_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_valid_res) |->
      (out_month_index <= 4'd11) && (out_hour_of_day <= 5'd23) &&
      (out_minute_of_hour <= 6'd59) && (out_second_of_minute <= 6'd59) &&
      (out_weekday <= 3'd6) && (out_day_of_year <= 9'd365) &&
      (out_day_of_month != 5'd0))
    else $error("calendar field out of range");

endmodule

`default_nettype wire

// ----- design/eps_cmpsub.sv -----
`default_nettype none

module eps_cmpsub
  import eps_pkg::*;
(
  input  wire logic [OPW-1:0] a,
  input  wire logic [OPW-1:0] b,
  output cs_res_t             res
);

  logic [OPW:0] d;

  assign d        = {1'b0, a} - {1'b0, b};
  assign res.ge   = ~d[OPW];
  assign res.diff = d[OPW-1:0];

endmodule

`default_nettype wire
